@@ hdl/spfl_pkg.sv @@
// ----------------------------------------------------------------------------
// spfl_pkg
// Shared types and constants for the slot pool with free list and expiry.
// ----------------------------------------------------------------------------
package spfl_pkg;

	// fixed field widths
	localparam int CMD_W    = 2;
	localparam int IDX_W    = 5;
	localparam int EL_W     = 16;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 5;
	localparam int AGE_W    = 32;

	// pool defaults
	localparam int              DEF_POOL_SIZE  = 32;
	localparam logic [AGE_W-1:0] LIFE_LIMIT_RST = 32'd1024000;

	// register index, taken from paddr bit 2
	localparam logic REG_LIFE_LIMIT = 1'b0;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_ALLOC     = 3'd0,
		STS_FULL      = 3'd1,
		STS_FREED     = 3'd2,
		STS_BAD_FREE  = 3'd3,
		STS_EXPIRED   = 3'd4,
		STS_TICK_NONE = 3'd5
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ALOC_LINK,
		S_TK_RD,
		S_TK_EV,
		S_TK_END
	} state_t;

	// age unit result
	typedef struct packed {
		logic             expire;
		logic [AGE_W-1:0] sum;
	} age_res_t;

endpackage

@@ hdl/spfl_ram.sv @@
// ----------------------------------------------------------------------------
// spfl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module spfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/spfl_link_store.sv @@
// ----------------------------------------------------------------------------
// spfl_link_store
// Free list links: a RAM plus one valid flag per entry, so an entry never
// written since reset reads as its reset link (index plus one).
// ----------------------------------------------------------------------------
module spfl_link_store #(
	parameter int POOL_SIZE = 32,
	localparam int SW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1,
	localparam int HW = $clog2(POOL_SIZE + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [SW-1:0] waddr,
	input  logic [HW-1:0] wdata,
	input  logic          re,
	input  logic [SW-1:0] raddr,
	output logic [HW-1:0] rdata
);

	logic [POOL_SIZE-1:0] valid_q;
	logic                 rd_valid_q;
	logic [SW-1:0]        rd_addr_q;
	logic [HW-1:0]        ram_rdata;

	spfl_ram #(
		.WIDTH(HW),
		.DEPTH(POOL_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// per-entry written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// remember what was read, alongside the ram read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
			rd_addr_q  <= '0;
		end else if (re) begin
			rd_valid_q <= valid_q[raddr];
			rd_addr_q  <= raddr;
		end
	end

	// unwritten entry links to the next index, the last one to the empty mark
	assign rdata = rd_valid_q ? ram_rdata : (HW'(rd_addr_q) + HW'(1));

endmodule

@@ hdl/spfl_age_unit.sv @@
// ----------------------------------------------------------------------------
// spfl_age_unit
// Shared age arithmetic: expiry compare and saturating age advance.
// ----------------------------------------------------------------------------
module spfl_age_unit (
	input  logic [spfl_pkg::AGE_W-1:0] age,
	input  logic [spfl_pkg::EL_W-1:0]  elapsed,
	input  logic [spfl_pkg::AGE_W-1:0] life_limit,
	output spfl_pkg::age_res_t         res
);

	import spfl_pkg::*;

	logic [AGE_W:0] sum_wide;

	// one adder with carry out for saturation
	assign sum_wide = {1'b0, age} + (AGE_W + 1)'(elapsed);

	always_comb begin
		res.expire = (life_limit < age);
		res.sum    = sum_wide[AGE_W] ? {AGE_W{1'b1}} : sum_wide[AGE_W-1:0];
	end

endmodule

@@ hdl/slot_pool_free_list_with_expiry.sv @@
// ----------------------------------------------------------------------------
// slot_pool_free_list_with_expiry
// Slot pool handed out through a LIFO free list, with a tick that ages the
// active slots and expires those past the life limit.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  s_*     | in        | tuser: cmd; tdata: slot_index, elapsed
//  m_*     | out       | tuser: status; tdata: slot; tlast: last
//  APB     | in        | life_limit at address 0
//
//  allocate passes through the execute and link states, free through execute;
//  a tick visits every slot in turn, passing over an inactive one and, for an
//  active one, reading the age RAM, then the shared age unit with write back.
//  s_tready is high only while the sequencer is idle; a beat may be taken
//  while a result still waits in the output register.
//  a stalled m_tready holds the sequencer at its next result.
//  reset restores the free list order 0, 1, 2 ... at once, with no clear pass.
// ----------------------------------------------------------------------------
module slot_pool_free_list_with_expiry #(
	parameter int POOL_SIZE = spfl_pkg::DEF_POOL_SIZE
) (
	input  logic        clk,
	input  logic        arst_n,
	// input command beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [4:0] slot_index, [20:5] elapsed, zero fill
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [4:0] slot, zero fill
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import spfl_pkg::*;

	localparam int SW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int HW = $clog2(POOL_SIZE + 1);

	// registers
	state_t               state_q, state_d;
	logic [AGE_W-1:0]     life_limit_q;
	cmd_t                 cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [EL_W-1:0]      el_q;
	logic [HW-1:0]        head_q;
	logic [POOL_SIZE-1:0] active_q;
	logic [SW-1:0]        i_q;
	logic                 pend_valid_q;
	logic [SW-1:0]        pend_slot_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic                 out_last_q;

	// derived conditions
	logic          out_free;
	logic          head_empty;
	logic [SW-1:0] head_slot;
	logic [SW-1:0] idx_slot;
	logic          idx_ok;
	logic          i_last;
	logic          i_active;
	age_res_t      age_res;

	// datapath controls
	logic              emit;
	status_t           e_status;
	logic [SLOT_W-1:0] e_slot;
	logic              e_last;
	logic              head_ld;
	logic [HW-1:0]     head_d;
	logic              act_set;
	logic              act_clr;
	logic [SW-1:0]     act_addr;
	logic              link_we;
	logic [SW-1:0]     link_waddr;
	logic              link_re;
	logic [HW-1:0]     link_rdata;
	logic              age_we;
	logic [SW-1:0]     age_waddr;
	logic [AGE_W-1:0]  age_wdata;
	logic              age_re;
	logic [AGE_W-1:0]  age_rdata;
	logic              i_clr;
	logic              i_inc;
	logic              pend_ld;
	logic              pend_clr;

	// link and age storage
	spfl_link_store #(
		.POOL_SIZE(POOL_SIZE)
	) u_links (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (head_q),
		.re    (link_re),
		.raddr (head_slot),
		.rdata (link_rdata)
	);

	spfl_ram #(
		.WIDTH(AGE_W),
		.DEPTH(POOL_SIZE)
	) u_ages (
		.clk  (clk),
		.we   (age_we),
		.waddr(age_waddr),
		.wdata(age_wdata),
		.re   (age_re),
		.raddr(i_q),
		.rdata(age_rdata)
	);

	spfl_age_unit u_age_unit (
		.age       (age_rdata),
		.elapsed   (el_q),
		.life_limit(life_limit_q),
		.res       (age_res)
	);

	assign out_free   = !out_valid_q || m_tready;
	assign head_empty = (head_q >= HW'(POOL_SIZE));
	assign head_slot  = SW'(head_q);
	assign idx_slot   = SW'(idx_q);
	assign idx_ok     = (int'(idx_q) < POOL_SIZE) && active_q[idx_slot];
	assign i_last     = (i_q == SW'(POOL_SIZE - 1));
	assign i_active   = active_q[i_q];

	// apb port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LIFE_LIMIT) ? life_limit_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_limit_q <= LIFE_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LIFE_LIMIT) begin
			life_limit_q <= pwdata;
		end
	end

	// input side
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= cmd_t'(s_tuser[1:0]);
			idx_q <= s_tdata[4:0];
			el_q  <= s_tdata[20:5];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_ALLOC: begin
						if (!head_empty) state_d = S_ALOC_LINK;
						else if (out_free) state_d = S_IDLE;
					end
					CMD_FREE: begin
						if (out_free) state_d = S_IDLE;
					end
					CMD_TICK: state_d = S_TK_RD;
					default:  state_d = S_IDLE;
				endcase
			end
			S_ALOC_LINK: begin
				if (out_free) state_d = S_IDLE;
			end
			S_TK_RD: begin
				if (i_active) state_d = S_TK_EV;
				else if (i_last) state_d = S_TK_END;
			end
			S_TK_EV: begin
				if (!(age_res.expire && pend_valid_q && !out_free)) begin
					state_d = i_last ? S_TK_END : S_TK_RD;
				end
			end
			S_TK_END: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		emit       = 1'b0;
		e_status   = STS_TICK_NONE;
		e_slot     = '0;
		e_last     = 1'b1;
		head_ld    = 1'b0;
		head_d     = head_q;
		act_set    = 1'b0;
		act_clr    = 1'b0;
		act_addr   = i_q;
		link_we    = 1'b0;
		link_waddr = i_q;
		link_re    = 1'b0;
		age_we     = 1'b0;
		age_waddr  = i_q;
		age_wdata  = age_res.sum;
		age_re     = 1'b0;
		i_clr      = 1'b0;
		i_inc      = 1'b0;
		pend_ld    = 1'b0;
		pend_clr   = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				case (cmd_q)
					CMD_ALLOC: begin
						if (head_empty) begin
							emit     = out_free;
							e_status = STS_FULL;
						end else begin
							// take the head slot, fetch its link
							link_re   = 1'b1;
							act_set   = 1'b1;
							act_addr  = head_slot;
							age_we    = 1'b1;
							age_waddr = head_slot;
							age_wdata = '0;
						end
					end
					CMD_FREE: begin
						if (out_free) begin
							emit   = 1'b1;
							e_slot = idx_q;
							if (idx_ok) begin
								e_status   = STS_FREED;
								act_clr    = 1'b1;
								act_addr   = idx_slot;
								link_we    = 1'b1;
								link_waddr = idx_slot;
								head_ld    = 1'b1;
								head_d     = HW'(idx_slot);
							end else begin
								e_status = STS_BAD_FREE;
							end
						end
					end
					CMD_TICK: i_clr = 1'b1;
					default: ;
				endcase
			end
			S_ALOC_LINK: begin
				if (out_free) begin
					emit     = 1'b1;
					e_status = STS_ALLOC;
					e_slot   = SLOT_W'(head_slot);
					head_ld  = 1'b1;
					head_d   = link_rdata;
				end
			end
			S_TK_RD: begin
				age_re = i_active;
				i_inc  = !i_active && !i_last;
			end
			S_TK_EV: begin
				if (age_res.expire) begin
					if (!pend_valid_q || out_free) begin
						// report the previous expiry, hold this one back
						emit     = pend_valid_q;
						e_status = STS_EXPIRED;
						e_slot   = SLOT_W'(pend_slot_q);
						e_last   = 1'b0;
						act_clr  = 1'b1;
						link_we  = 1'b1;
						head_ld  = 1'b1;
						head_d   = HW'(i_q);
						pend_ld  = 1'b1;
						i_inc    = !i_last;
					end
				end else begin
					age_we = 1'b1;
					i_inc  = !i_last;
				end
			end
			S_TK_END: begin
				if (out_free) begin
					emit     = 1'b1;
					pend_clr = 1'b1;
					if (pend_valid_q) begin
						e_status = STS_EXPIRED;
						e_slot   = SLOT_W'(pend_slot_q);
					end
				end
			end
			default: ;
		endcase
	end

	// state, list head, active flags, tick counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			active_q     <= '0;
			i_q          <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (head_ld) head_q <= head_d;
			if (act_set) active_q[act_addr] <= 1'b1;
			if (act_clr) active_q[act_addr] <= 1'b0;
			if (i_clr) i_q <= '0;
			else if (i_inc) i_q <= i_q + SW'(1);
			if (pend_clr) pend_valid_q <= 1'b0;
			else if (pend_ld) pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_ld) pend_slot_q <= i_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= e_status;
			out_slot_q   <= e_slot;
			out_last_q   <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_slot_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

@@ tb/tb_slot_pool_free_list_with_expiry.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_pool_free_list_with_expiry
// Self-checking bench for the slot pool. Command beats are queued by the
// stimulus process and driven onto the input stream. Each beat taken by the
// block updates a local copy of the free list, flags and ages, which produces
// the result beats due. The monitor pops those in order and compares status,
// slot and last. The life limit is rewritten between phases, and both stream
// sides back off at random.
// ----------------------------------------------------------------------------
module tb_slot_pool_free_list_with_expiry;
	import spfl_pkg::*;

	localparam int          POOL_N          = DEF_POOL_SIZE;
	localparam logic [2:0]  LIFE_LIMIT_ADDR = {REG_LIFE_LIMIT, 2'b00};
	localparam int          STALL_LIMIT     = 4000;
	localparam int          SETTLE_CYCLES   = 80;

	typedef struct packed {
		cmd_t        cmd;
		logic [4:0]  slot_index;
		logic [15:0] elapsed;
	} cmd_beat_t;

	typedef struct {
		status_t    status;
		logic [4:0] slot;
		logic       last;
	} pool_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // [4:0] slot_index, [20:5] elapsed, zero fill
	logic [1:0]  s_tuser  = '0;   // [1:0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [4:0] slot, zero fill
	logic [2:0]  m_tuser;         // [2:0] status
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the pool
	int          pool_head;
	int          pool_link [POOL_N];
	bit          pool_live [POOL_N];
	logic [31:0] pool_age  [POOL_N];
	logic [31:0] life_limit_q;

	cmd_beat_t    cmd_queue[$];
	pool_result_t due_results[$];
	cmd_beat_t    drv_beat;
	pool_result_t want;
	int           src_idle_pct = 0;
	int           snk_idle_pct = 0;
	int           gen_live     = 0;
	int           n_errors     = 0;
	int           quiet_cycles = 0;

	slot_pool_free_list_with_expiry u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// free list order 0, 1, 2 ... and default limit
	function automatic void pool_reset();
		int i;
		for (i = 0; i < POOL_N; i++) begin
			pool_link[i] = i + 1;
			pool_live[i] = 1'b0;
			pool_age[i]  = '0;
		end
		pool_head    = 0;
		life_limit_q = LIFE_LIMIT_RST;
	endfunction

	// push a slot back on the list head
	function automatic void pool_release(input int s);
		pool_live[s] = 1'b0;
		pool_link[s] = pool_head;
		pool_head    = s;
	endfunction

	// add one result beat at the tail of the pending list
	function automatic void due_add(input status_t st, input logic [4:0] sl,
			input logic lt);
		pool_result_t r;
		r.status = st;
		r.slot   = sl;
		r.last   = lt;
		due_results.insert(due_results.size(), r);
	endfunction

	// apply one accepted command beat and queue the results it causes
	function automatic void pool_apply(input cmd_t cmd, input logic [4:0] idx,
			input logic [15:0] el);
		int          s;
		int          i;
		int          n_exp;
		int          k;
		logic [32:0] sum;
		case (cmd)
			CMD_ALLOC: begin
				s = pool_head;
				if (s >= POOL_N) begin
					due_add(STS_FULL, 5'd0, 1'b1);
				end else begin
					pool_head    = pool_link[s];
					pool_live[s] = 1'b1;
					pool_age[s]  = '0;
					due_add(STS_ALLOC, 5'(s), 1'b1);
				end
			end
			CMD_FREE: begin
				if (int'(idx) >= POOL_N || !pool_live[idx]) begin
					due_add(STS_BAD_FREE, idx, 1'b1);
				end else begin
					pool_release(int'(idx));
					due_add(STS_FREED, idx, 1'b1);
				end
			end
			CMD_TICK: begin
				// expiry depends on each slot alone, so count first to place last
				n_exp = 0;
				for (i = 0; i < POOL_N; i++)
					if (pool_live[i] && pool_age[i] > life_limit_q)
						n_exp++;
				k = 0;
				for (i = 0; i < POOL_N; i++) begin
					if (pool_live[i]) begin
						if (pool_age[i] > life_limit_q) begin
							k++;
							pool_release(i);
							due_add(STS_EXPIRED, 5'(i), (k == n_exp) ? 1'b1 : 1'b0);
						end else begin
							sum = {1'b0, pool_age[i]} + {17'd0, el};
							pool_age[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						end
					end
				end
				if (n_exp == 0)
					due_add(STS_TICK_NONE, 5'd0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	// input stream driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				pool_apply(cmd_t'(s_tuser), s_tdata[4:0], s_tdata[20:5]);
			if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				drv_beat = cmd_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {3'b000, drv_beat.elapsed, drv_beat.slot_index};
				s_tuser  <= drv_beat.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("result beat with nothing pending: status %0d slot %0d",
						m_tuser, m_tdata);
					n_errors++;
				end else begin
					want = due_results.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						n_errors++;
					end
					if (m_tdata !== {3'b000, want.slot}) begin
						$error("slot: expected %0d, got %0d", want.slot, m_tdata);
						n_errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_tlast);
						n_errors++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// watchdog on cycles with no beat and no register access
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(psel && penable && pready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_slot_pool_free_list_with_expiry: done, errors");
				$finish;
			end
		end
	end

	task automatic queue_beat(input cmd_t cmd, input logic [4:0] idx,
			input logic [15:0] el);
		cmd_beat_t b;
		b.cmd        = cmd;
		b.slot_index = idx;
		b.elapsed    = el;
		cmd_queue.insert(cmd_queue.size(), b);
	endtask

	// elapsed time with the two extremes weighted up
	function automatic logic [15:0] rand_elapsed();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	// random commands; frees mostly aim at slots likely to be live
	task automatic queue_random(input int count);
		int made;
		int roll;
		int hi;
		int k;
		made = 0;
		while (made < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				// allocation burst, long enough to run the free list dry
				k = (gen_live < 31) ? 33 - gen_live : 2;
				repeat (k)
					queue_beat(CMD_ALLOC, 5'($urandom_range(0, 31)), rand_elapsed());
				made += k;
				gen_live = POOL_N;
			end else if (roll < 40) begin
				queue_beat(CMD_ALLOC, 5'($urandom_range(0, 31)), rand_elapsed());
				made++;
				if (gen_live < POOL_N)
					gen_live++;
			end else if (roll < 72) begin
				hi = (gen_live + 2 > 31) ? 31 : gen_live + 2;
				if ($urandom_range(0, 9) < 8)
					queue_beat(CMD_FREE, 5'($urandom_range(0, hi)), rand_elapsed());
				else
					queue_beat(CMD_FREE, 5'($urandom_range(0, 31)), rand_elapsed());
				made++;
				if (gen_live > 0)
					gen_live--;
			end else if (roll < 95) begin
				queue_beat(CMD_TICK, 5'($urandom_range(0, 31)), rand_elapsed());
				made++;
				gen_live -= gen_live / 4;
			end else begin
				// ignored command, does not count
				queue_beat(CMD_NONE, 5'($urandom_range(0, 31)), rand_elapsed());
			end
		end
	endtask

	// wait until every beat is taken and answered, then let the block go quiet
	task automatic settle();
		@(posedge clk);
		while (cmd_queue.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_life_limit(input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIFE_LIMIT_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		life_limit_q = value;
	endtask

	// reset, directed checks, then three random phases
	initial begin
		pool_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 35;
		snk_idle_pct = 55;

		// default limit: allocation order, frees, rejected frees, quiet ticks
		queue_beat(CMD_ALLOC, 5'd0, 16'h0000);
		queue_beat(CMD_ALLOC, 5'd31, 16'hFFFF);
		queue_beat(CMD_ALLOC, 5'd0, 16'h0000);
		queue_beat(CMD_FREE, 5'd1, 16'h0000);
		queue_beat(CMD_FREE, 5'd1, 16'hFFFF);
		queue_beat(CMD_FREE, 5'd31, 16'h0000);
		queue_beat(CMD_ALLOC, 5'd0, 16'h0000);
		queue_beat(CMD_NONE, 5'd31, 16'hFFFF);
		queue_beat(CMD_TICK, 5'd0, 16'h0000);
		queue_beat(CMD_TICK, 5'd31, 16'hFFFF);
		settle();

		// zero limit: multi-slot expiry, list reuse after expiry
		write_life_limit(32'd0);
		queue_beat(CMD_TICK, 5'd0, 16'h0000);
		queue_beat(CMD_ALLOC, 5'd0, 16'h0000);
		queue_beat(CMD_TICK, 5'd0, 16'h0001);
		queue_beat(CMD_TICK, 5'd0, 16'h0000);
		queue_beat(CMD_FREE, 5'd2, 16'h0000);
		queue_beat(CMD_ALLOC, 5'd0, 16'h0000);
		queue_beat(CMD_ALLOC, 5'd0, 16'h0000);
		queue_beat(CMD_FREE, 5'd2, 16'h0000);
		settle();
		gen_live = 1;

		write_life_limit(32'($urandom_range(0, 150000)));
		queue_random(48);
		settle();

		src_idle_pct = 55;
		snk_idle_pct = 35;
		write_life_limit(32'hFFFF_FFFF);
		queue_random(48);
		settle();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_life_limit(32'd0);
		queue_random(48);
		settle();

		if (n_errors == 0)
			$display("tb_slot_pool_free_list_with_expiry: done, clean");
		else
			$display("tb_slot_pool_free_list_with_expiry: done, errors");
		$finish;
	end

endmodule

@@ slot_pool_free_list_with_expiry.f @@
hdl/spfl_pkg.sv
hdl/spfl_ram.sv
hdl/spfl_link_store.sv
hdl/spfl_age_unit.sv
hdl/slot_pool_free_list_with_expiry.sv
tb/tb_slot_pool_free_list_with_expiry.sv
